### rtl/ipv4_rx_header_checker_defines.svh
// Assertion macros for the IPv4 receive header checker RTL.
// Included by modules that carry concurrent assertions; expects clk and rst_n in scope.
`ifndef IPV4_RX_HEADER_CHECKER_DEFINES_SVH
`define IPV4_RX_HEADER_CHECKER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define IPV4RX_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define IPV4RX_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ipv4rx_pkg.sv
// Shared types, constants and status codes for the IPv4 receive header checker.
// No dependencies; imported by every module of the block.
package ipv4rx_pkg;

    // Frame layout
    localparam int          DEFAULT_MAX_FRAME_BYTES = 2048;
    localparam int          POS_W                   = 16;
    localparam logic [15:0] IPV4_ETHERTYPE          = 16'h0800;
    localparam logic [15:0] SUM_GOOD                = 16'hFFFF;
    localparam logic [15:0] ETH_HDR_LEN             = 16'd14;
    localparam logic [15:0] MIN_FRAME_LEN           = 16'd34;
    localparam logic [3:0]  IP_VERSION_4            = 4'd4;

    // Byte positions within the frame
    localparam logic [15:0] POS_ETYPE_HI = 16'd12;
    localparam logic [15:0] POS_ETYPE_LO = 16'd13;
    localparam logic [15:0] POS_VIHL     = 16'd14;
    localparam logic [15:0] POS_TLEN_HI  = 16'd16;
    localparam logic [15:0] POS_TLEN_LO  = 16'd17;
    localparam logic [15:0] POS_PROTO    = 16'd23;
    localparam logic [15:0] POS_SRC_FIRST = 16'd26;
    localparam logic [15:0] POS_SRC_LAST  = 16'd29;
    localparam logic [15:0] POS_DST_FIRST = 16'd30;
    localparam logic [15:0] POS_DST_LAST  = 16'd33;

    // Status codes
    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_NOT_IPV4     = 3'd1;
    localparam logic [2:0] ST_TOO_SHORT    = 3'd2;
    localparam logic [2:0] ST_BAD_VERSION  = 3'd3;
    localparam logic [2:0] ST_BAD_CHECKSUM = 3'd4;
    localparam logic [2:0] ST_LENGTH_ERROR = 3'd5;

    // Header fields gathered over one frame
    typedef struct packed {
        logic [POS_W-1:0] frame_len;
        logic [15:0]      ethertype;
        logic [7:0]       version_ihl;
        logic [15:0]      total_length;
        logic [7:0]       protocol;
        logic [31:0]      source_address;
        logic [31:0]      destination_address;
        logic [15:0]      ones_sum;
    } frame_sum_t;

    // One result; last field sits in the lowest bits
    typedef struct packed {
        logic [15:0] payload_length;
        logic [6:0]  payload_offset;
        logic [7:0]  protocol;
        logic [31:0] destination_address;
        logic [31:0] source_address;
        logic [2:0]  status;
    } result_t;

    localparam int RESULT_W = $bits(result_t);
    localparam int TDATA_W  = ((RESULT_W + 7) / 8) * 8;

endpackage

### rtl/ipv4rx_parser.sv
// Per-byte frame parser: byte position, header field capture and header checksum sum.
// Depends on ipv4rx_pkg.
module ipv4rx_parser
    import ipv4rx_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = DEFAULT_MAX_FRAME_BYTES
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_go,
    input  logic [7:0] byte_data,
    input  logic       byte_last,
    output frame_sum_t summary
);

    logic [POS_W-1:0] pos_reg,       pos_next,       upd_pos;
    logic [15:0]      etype_reg,     etype_next,     upd_etype;
    logic [7:0]       vihl_reg,      vihl_next,      upd_vihl;
    logic [15:0]      tlen_reg,      tlen_next,      upd_tlen;
    logic [7:0]       proto_reg,     proto_next,     upd_proto;
    logic [31:0]      src_reg,       src_next,       upd_src;
    logic [31:0]      dst_reg,       dst_next,       upd_dst;
    logic [15:0]      sum_reg,       sum_next,       upd_sum;
    logic [7:0]       pend_reg,      pend_next,      upd_pend;

    logic             take;
    logic [5:0]       hlen;
    logic [15:0]      hdr_idx;
    logic [16:0]      raw_sum;
    logic             frame_end;

    // Apply the current byte to the frame state
    always_comb
    begin
        take      = byte_go && (pos_reg < POS_W'(MAX_FRAME_BYTES));
        upd_pos   = pos_reg;
        upd_etype = etype_reg;
        upd_vihl  = vihl_reg;
        upd_tlen  = tlen_reg;
        upd_proto = proto_reg;
        upd_src   = src_reg;
        upd_dst   = dst_reg;
        upd_sum   = sum_reg;
        upd_pend  = pend_reg;
        hdr_idx   = pos_reg - ETH_HDR_LEN;
        raw_sum   = {1'b0, sum_reg} + {1'b0, pend_reg, byte_data};

        if (take)
        begin
            upd_pos = pos_reg + 1'b1;
            if (pos_reg == POS_ETYPE_HI) upd_etype[15:8] = byte_data;
            if (pos_reg == POS_ETYPE_LO) upd_etype[7:0]  = byte_data;
            if (pos_reg == POS_VIHL)     upd_vihl        = byte_data;
            if (pos_reg == POS_TLEN_HI)  upd_tlen[15:8]  = byte_data;
            if (pos_reg == POS_TLEN_LO)  upd_tlen[7:0]   = byte_data;
            if (pos_reg == POS_PROTO)    upd_proto       = byte_data;
            if (pos_reg >= POS_SRC_FIRST && pos_reg <= POS_SRC_LAST)
                upd_src = {src_reg[23:0], byte_data};
            if (pos_reg >= POS_DST_FIRST && pos_reg <= POS_DST_LAST)
                upd_dst = {dst_reg[23:0], byte_data};
        end

        // header length follows the IHL nibble, including this very byte
        hlen = {upd_vihl[3:0], 2'b00};

        // checksum: even header bytes wait, odd ones complete a word
        if (take && (pos_reg >= ETH_HDR_LEN) && (hdr_idx < {10'd0, hlen}))
        begin
            if (!pos_reg[0])
                upd_pend = byte_data;
            else
                upd_sum = raw_sum[15:0] + {15'd0, raw_sum[16]};
        end
    end

    assign frame_end = byte_go && byte_last;

    // Clear the frame state after the last byte
    always_comb
    begin
        pos_next   = frame_end ? '0 : upd_pos;
        etype_next = frame_end ? '0 : upd_etype;
        vihl_next  = frame_end ? '0 : upd_vihl;
        tlen_next  = frame_end ? '0 : upd_tlen;
        proto_next = frame_end ? '0 : upd_proto;
        src_next   = frame_end ? '0 : upd_src;
        dst_next   = frame_end ? '0 : upd_dst;
        sum_next   = frame_end ? '0 : upd_sum;
        pend_next  = frame_end ? '0 : upd_pend;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            etype_reg <= '0;
            vihl_reg  <= '0;
            tlen_reg  <= '0;
            proto_reg <= '0;
            src_reg   <= '0;
            dst_reg   <= '0;
            sum_reg   <= '0;
            pend_reg  <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            etype_reg <= etype_next;
            vihl_reg  <= vihl_next;
            tlen_reg  <= tlen_next;
            proto_reg <= proto_next;
            src_reg   <= src_next;
            dst_reg   <= dst_next;
            sum_reg   <= sum_next;
            pend_reg  <= pend_next;
        end
    end

    // Frame view including the current byte
    always_comb
    begin
        summary.frame_len           = upd_pos;
        summary.ethertype           = upd_etype;
        summary.version_ihl         = upd_vihl;
        summary.total_length        = upd_tlen;
        summary.protocol            = upd_proto;
        summary.source_address      = upd_src;
        summary.destination_address = upd_dst;
        summary.ones_sum            = upd_sum;
    end

endmodule

### rtl/ipv4rx_verdict.sv
// Frame verdict: status checks in priority order and the result fields.
// Depends on ipv4rx_pkg.
module ipv4rx_verdict
    import ipv4rx_pkg::*;
(
    input  frame_sum_t summary,
    input  logic       verify_checksum,
    output result_t    result
);

    logic [5:0]  hlen;
    logic [6:0]  offset;
    logic [2:0]  status;

    always_comb
    begin
        hlen   = {summary.version_ihl[3:0], 2'b00};
        offset = 7'(ETH_HDR_LEN) + {1'b0, hlen};

        // first failing check wins
        if (summary.ethertype != IPV4_ETHERTYPE)
            status = ST_NOT_IPV4;
        else if (summary.frame_len < MIN_FRAME_LEN)
            status = ST_TOO_SHORT;
        else if (summary.version_ihl[7:4] != IP_VERSION_4)
            status = ST_BAD_VERSION;
        else if (({9'd0, offset} > summary.frame_len)
                 || (summary.total_length < {10'd0, hlen}))
            status = ST_LENGTH_ERROR;
        else if (verify_checksum && (summary.ones_sum != SUM_GOOD))
            status = ST_BAD_CHECKSUM;
        else
            status = ST_OK;

        // fields are zeroed on any error
        result.status = status;
        if (status == ST_OK)
        begin
            result.source_address      = summary.source_address;
            result.destination_address = summary.destination_address;
            result.protocol            = summary.protocol;
            result.payload_offset      = offset;
            result.payload_length      = summary.total_length - {10'd0, hlen};
        end
        else
        begin
            result.source_address      = '0;
            result.destination_address = '0;
            result.protocol            = '0;
            result.payload_offset      = '0;
            result.payload_length      = '0;
        end
    end

endmodule

### rtl/ipv4rx_out_buf.sv
// Result register with a one-entry skid stage in front of the output channel.
// Depends on ipv4rx_pkg and ipv4_rx_header_checker_defines.svh.
`include "ipv4_rx_header_checker_defines.svh"

module ipv4rx_out_buf
    import ipv4rx_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t load_data,
    output logic    skid_full,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    take;

    assign take = main_valid_reg && out_ready;

    // Refill the main register from the skid stage first, then from the load
    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (load)
        begin
            if (!main_valid_reg || take)
            begin
                main_next       = load_data;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = load_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (take)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign skid_full = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    // skid entry only ever sits behind a full main register
    `IPV4RX_ASSERT_NOW(a_skid_behind_main, skid_valid_reg, main_valid_reg, "skid full, main empty")
    // upstream must hold results while the skid stage is full
    `IPV4RX_ASSERT_NOW(a_no_load_when_full, skid_valid_reg, !load, "result lost: skid full")
    // draining the skid stage keeps the output valid
    `IPV4RX_ASSERT_NEXT(a_skid_drain, take && skid_valid_reg, main_valid_reg, "skid drain dropped")

endmodule

### rtl/ipv4_rx_header_checker.sv
// Top level of the IPv4 receive header checker: input register, parser, verdict, output.
// Depends on ipv4rx_pkg, ipv4rx_parser, ipv4rx_verdict and ipv4rx_out_buf.
//
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+---------------------------------------------
//  s_*      | in  | s_tvalid / s_tready  | s_tdata = frame_byte, s_tlast = last_byte
//  m_*      | out | m_tvalid / m_tready  | m_tdata = status .. payload_length
//  cfg_*    | in  | cfg_wr_en            | cfg_wr_data = verify_checksum
//
// One frame byte per cycle is taken unless stalled; parser state updates in a single pass.
// A result enters the output or skid register as its last byte leaves the input register.
// Reset returns all frame state to zero and sets verify_checksum; no clearing pass.
// Output stalls are absorbed by the result register and one skid entry; only a
// last byte waits in the input register while both are full.
module ipv4_rx_header_checker
    import ipv4rx_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = DEFAULT_MAX_FRAME_BYTES
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] frame_byte
    input  logic               s_tlast,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // [2:0] status, [34:3] source_address,
                                          // [66:35] destination_address, [74:67] protocol,
                                          // [81:75] payload_offset, [97:82] payload_length
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       verify_reg;
    logic       in_go;
    logic       skid_full;
    frame_sum_t summary;
    result_t    verdict;
    result_t    out_data;

    // Input stage moves on unless a last byte has nowhere to put its result
    assign in_go    = in_valid_reg && (!in_last_reg || !skid_full);
    assign s_tready = !in_valid_reg || in_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tvalid && s_tready)
            in_valid_reg <= 1'b1;
        else if (in_go)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Checksum enable register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            verify_reg <= 1'b1;
        else if (cfg_wr_en)
            verify_reg <= cfg_wr_data;
    end

    ipv4rx_parser #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_go   (in_go),
        .byte_data (in_byte_reg),
        .byte_last (in_last_reg),
        .summary   (summary)
    );

    ipv4rx_verdict u_verdict (
        .summary         (summary),
        .verify_checksum (verify_reg),
        .result          (verdict)
    );

    ipv4rx_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (in_go && in_last_reg),
        .load_data (verdict),
        .skid_full (skid_full),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = {(TDATA_W - RESULT_W)'(0), out_data};

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for ipv4_rx_header_checker: streams Ethernet frames byte by byte
// and checks each frame verdict against an internal model of the header parser.
// Depends on ipv4rx_pkg and the ipv4_rx_header_checker RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ipv4rx_pkg::*;

    localparam int CLK_PERIOD      = 12;
    localparam int MAX_BYTES       = DEFAULT_MAX_FRAME_BYTES;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 6;
    localparam int DRAIN_CYCLES    = 8;
    localparam int RANDOM_BYTES    = 600;
    localparam int RANDOM_VERDICTS = 15;
    localparam int RUN_LIMIT_NS    = 10_000_000;

    // Model of the frame parser plus the queue of verdicts still owed by the block
    class frame_verdict_tracker;
        bit          verify_en;
        int          position;
        logic [15:0] ethertype;
        logic [7:0]  vihl;
        logic [15:0] total_len;
        logic [7:0]  proto;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] hdr_sum;
        logic [7:0]  high_byte;
        result_t     verdicts_due[$];
        int          verdicts_made;
        int          fail_count;

        function new();
            verify_en     = 1'b1;
            verdicts_made = 0;
            fail_count    = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            position  = 0;
            ethertype = '0;
            vihl      = '0;
            total_len = '0;
            proto     = '0;
            src_addr  = '0;
            dst_addr  = '0;
            hdr_sum   = '0;
            high_byte = '0;
        endfunction

        // Take one accepted frame byte; on the last byte, queue the verdict
        function void absorb_byte(logic [7:0] b, logic last);
            int          hlen;
            int          h;
            logic [16:0] acc;
            result_t     r;
            if (position < MAX_BYTES) begin
                if (position == POS_ETYPE_HI) ethertype[15:8] = b;
                if (position == POS_ETYPE_LO) ethertype[7:0] = b;
                if (position == POS_VIHL) vihl = b;
                if (position == POS_TLEN_HI) total_len[15:8] = b;
                if (position == POS_TLEN_LO) total_len[7:0] = b;
                if (position == POS_PROTO) proto = b;
                if (position >= POS_SRC_FIRST && position <= POS_SRC_LAST)
                    src_addr = {src_addr[23:0], b};
                if (position >= POS_DST_FIRST && position <= POS_DST_LAST)
                    dst_addr = {dst_addr[23:0], b};
                // ones-complement sum over the IHL*4 header bytes
                if (position >= ETH_HDR_LEN) begin
                    h    = position - int'(ETH_HDR_LEN);
                    hlen = int'(vihl[3:0]) * 4;
                    if (h < hlen) begin
                        if (h % 2 == 0) begin
                            high_byte = b;
                        end
                        else begin
                            acc     = {1'b0, hdr_sum} + {1'b0, high_byte, b};
                            hdr_sum = acc[15:0] + 16'(acc[16]);
                        end
                    end
                end
                position++;
            end
            if (!last) return;

            hlen = int'(vihl[3:0]) * 4;
            r    = '0;
            if (ethertype != IPV4_ETHERTYPE)
                r.status = ST_NOT_IPV4;
            else if (position < int'(MIN_FRAME_LEN))
                r.status = ST_TOO_SHORT;
            else if (vihl[7:4] != IP_VERSION_4)
                r.status = ST_BAD_VERSION;
            else if (int'(ETH_HDR_LEN) + hlen > position || int'(total_len) < hlen)
                r.status = ST_LENGTH_ERROR;
            else if (verify_en && hdr_sum != SUM_GOOD)
                r.status = ST_BAD_CHECKSUM;
            else begin
                r.status              = ST_OK;
                r.source_address      = src_addr;
                r.destination_address = dst_addr;
                r.protocol            = proto;
                r.payload_offset      = 7'(int'(ETH_HDR_LEN) + hlen);
                r.payload_length      = 16'(int'(total_len) - hlen);
            end
            verdicts_due.push_back(r);
            verdicts_made++;
            clear_frame();
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h",
                         $time, name, want, got);
                fail_count++;
            end
        endfunction

        // Compare one verdict leaving the block with the oldest one owed
        function void check_result(logic [TDATA_W-1:0] data);
            result_t got;
            result_t want;
            got = data[RESULT_W-1:0];
            if (verdicts_due.size() == 0) begin
                $display("%0t ns: unexpected verdict, expected none, got 0x%0h",
                         $time, got);
                fail_count++;
                return;
            end
            want = verdicts_due.pop_front();
            check_field("status", 32'(want.status), 32'(got.status));
            check_field("source_address", want.source_address, got.source_address);
            check_field("destination_address", want.destination_address,
                        got.destination_address);
            check_field("protocol", 32'(want.protocol), 32'(got.protocol));
            check_field("payload_offset", 32'(want.payload_offset), 32'(got.payload_offset));
            check_field("payload_length", 32'(want.payload_length), 32'(got.payload_length));
        endfunction
    endclass

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               s_tvalid    = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata     = '0;
    logic               s_tlast     = 1'b0;
    logic               m_tvalid;
    logic               m_tready    = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic               cfg_wr_en   = 1'b0;
    logic               cfg_wr_data = 1'b0;

    frame_verdict_tracker tracker;
    logic [7:0]           frame_buf[$];
    bit                   hold_off_req = 1'b0;
    int                   rx_stall_max = 12;
    int                   random_bytes = 0;

    ipv4_rx_header_checker i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Transfers and register writes seen at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && cfg_wr_en) tracker.verify_en = cfg_wr_data;
        if (rst_n && s_tvalid && s_tready) tracker.absorb_byte(s_tdata, s_tlast);
        if (rst_n && m_tvalid && m_tready) tracker.check_result(m_tdata);
    end

    // Result sink: random stall per verdict, one long hold-off on request
    initial
    begin
        int stall;
        wait (rst_n);
        forever begin
            @(negedge clk);
            if (hold_off_req) begin
                stall        = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
            end
            else begin
                stall = $urandom_range(0, rx_stall_max);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // Header frame: MACs, ethertype, header of max(IHL*4, 20) bytes, payload
    function automatic void build_ip_frame(logic [15:0] etype, logic [3:0] version,
                                           logic [3:0] ihl, logic [15:0] tot_len,
                                           int payload, int cut_len, bit fix_sum);
        int          hlen;
        int          hdr_area;
        logic [16:0] acc;
        logic [15:0] sum;
        hlen     = int'(ihl) * 4;
        hdr_area = (hlen > 20) ? hlen : 20;
        frame_buf.delete();
        repeat (12) frame_buf.push_back(8'($urandom));
        frame_buf.push_back(etype[15:8]);
        frame_buf.push_back(etype[7:0]);
        repeat (hdr_area) frame_buf.push_back(8'($urandom));
        frame_buf[14] = {version, ihl};
        frame_buf[16] = tot_len[15:8];
        frame_buf[17] = tot_len[7:0];
        // checksum word lies at header bytes 10-11, so only for IHL of 3 and up
        if (fix_sum && hlen >= 12) begin
            frame_buf[24] = 8'h00;
            frame_buf[25] = 8'h00;
            sum = '0;
            for (int i = 0; i < hlen; i += 2) begin
                acc = {1'b0, sum} + {1'b0, frame_buf[14 + i], frame_buf[15 + i]};
                sum = acc[15:0] + 16'(acc[16]);
            end
            frame_buf[24] = ~sum[15:8];
            frame_buf[25] = ~sum[7:0];
        end
        repeat (payload) frame_buf.push_back(8'($urandom));
        if (cut_len > 0) begin
            while (frame_buf.size() > cut_len) void'(frame_buf.pop_back());
            while (frame_buf.size() < cut_len) frame_buf.push_back(8'($urandom));
        end
    endfunction

    function automatic void build_raw_frame(int len, bit force_ipv4);
        frame_buf.delete();
        repeat (len) frame_buf.push_back(8'($urandom));
        if (force_ipv4 && len >= 14) begin
            frame_buf[12] = IPV4_ETHERTYPE[15:8];
            frame_buf[13] = IPV4_ETHERTYPE[7:0];
        end
    endfunction

    function automatic logic [15:0] pick_total_len(int hlen, int payload);
        case ($urandom_range(0, 2))
            0:       return 16'(hlen);
            1:       return 16'(hlen + payload);
            default: return 16'($urandom_range(hlen, 65535));
        endcase
    endfunction

    task automatic send_byte(logic [7:0] b, logic last, int gap);
        @(negedge clk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic send_frame(int gap_max);
        int n;
        n = frame_buf.size();
        for (int i = 0; i < n; i++)
            send_byte(frame_buf[i], i == n - 1, $urandom_range(0, gap_max));
        random_bytes += n;
    endtask

    task automatic send_ip(logic [15:0] etype, logic [3:0] version, logic [3:0] ihl,
                           logic [15:0] tot_len, int payload, int cut_len, bit fix_sum);
        build_ip_frame(etype, version, ihl, tot_len, payload, cut_len, fix_sum);
        send_frame(12);
    endtask

    // Drain every owed verdict, let the pipeline settle, then write the register
    task automatic idle_and_configure(bit verify);
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (tracker.verdicts_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= verify;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // One random frame, mostly well-formed headers with random content
    task automatic make_random_frame();
        int          kind;
        int          payload;
        int          v;
        logic [3:0]  ihl;
        logic [15:0] etype;
        kind    = $urandom_range(0, 99);
        payload = $urandom_range(0, 16);
        ihl     = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(6, 15)) : 4'd5;
        if (kind < 63) begin
            // good header; some with a corrupted checksum
            build_ip_frame(IPV4_ETHERTYPE, IP_VERSION_4, ihl,
                           pick_total_len(int'(ihl) * 4, payload), payload, 0, kind < 55);
        end
        else if (kind < 69) begin
            v = $urandom_range(0, 14);
            if (v >= 4) v++;
            build_ip_frame(IPV4_ETHERTYPE, 4'(v), ihl,
                           pick_total_len(int'(ihl) * 4, payload), payload, 0, 1'b1);
        end
        else if (kind < 75) begin
            etype = 16'($urandom);
            if (etype == IPV4_ETHERTYPE) etype[0] = 1'b1;
            build_ip_frame(etype, IP_VERSION_4, ihl, 16'($urandom), payload, 0, 1'b1);
        end
        else if (kind < 81) begin
            build_raw_frame($urandom_range(1, 33), 1'($urandom_range(0, 1)));
        end
        else if (kind < 87) begin
            // header running past the frame end, or total length under header length
            if ($urandom_range(0, 1) == 0) begin
                build_ip_frame(IPV4_ETHERTYPE, IP_VERSION_4, 4'd15, 16'hFFFF, 0,
                               $urandom_range(34, 73), 1'b1);
            end
            else begin
                ihl = 4'($urandom_range(5, 15));
                build_ip_frame(IPV4_ETHERTYPE, IP_VERSION_4, ihl,
                               16'($urandom_range(0, int'(ihl) * 4 - 1)), payload, 0, 1'b1);
            end
        end
        else if (kind < 93) begin
            ihl = 4'($urandom_range(0, 4));
            build_ip_frame(IPV4_ETHERTYPE, IP_VERSION_4, ihl, 16'($urandom), payload, 0,
                           1'b1);
        end
        else begin
            build_raw_frame($urandom_range(34, 64), 1'($urandom_range(0, 1)));
        end
    endtask

    // Run limit
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("FAIL ipv4_rx_header_checker");
        $finish;
    end

    // Stimulus
    initial
    begin
        int frame_count;
        int tx_gap_max;
        tracker = new();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed frames with checksum checking on
        idle_and_configure(1'b1);
        send_ip(IPV4_ETHERTYPE, IP_VERSION_4, 4'd5, 16'd20, 0, 0, 1'b1);   // minimum frame
        send_ip(IPV4_ETHERTYPE, IP_VERSION_4, 4'd15, 16'hFFFF, 3, 0, 1'b1);
        send_ip(16'h0000, IP_VERSION_4, 4'd5, 16'd20, 0, 0, 1'b1);
        send_ip(16'hFFFF, IP_VERSION_4, 4'd5, 16'd20, 0, 0, 1'b1);
        build_raw_frame(1, 1'b0);
        send_frame(12);
        build_raw_frame(20, 1'b1);                                         // too short
        send_frame(0);
        send_ip(IPV4_ETHERTYPE, 4'hF, 4'd5, 16'd40, 6, 0, 1'b1);
        send_ip(IPV4_ETHERTYPE, 4'h0, 4'd5, 16'd40, 6, 0, 1'b1);
        send_ip(IPV4_ETHERTYPE, IP_VERSION_4, 4'd15, 16'd60, 0, 40, 1'b1);  // past frame end
        send_ip(IPV4_ETHERTYPE, IP_VERSION_4, 4'd5, 16'd19, 0, 0, 1'b1);    // length under hlen
        send_ip(IPV4_ETHERTYPE, IP_VERSION_4, 4'd6, 16'd30, 4, 0, 1'b0);    // bad checksum
        send_ip(IPV4_ETHERTYPE, IP_VERSION_4, 4'd0, 16'd0, 0, 0, 1'b1);     // small IHL
        send_ip(IPV4_ETHERTYPE, IP_VERSION_4, 4'd4, 16'd50, 0, 0, 1'b1);
        frame_buf.delete();
        repeat (34) frame_buf.push_back(8'h00);
        send_frame(0);
        frame_buf.delete();
        repeat (34) frame_buf.push_back(8'hFF);
        send_frame(0);
        // long frame: bytes past the size limit are dropped
        build_ip_frame(IPV4_ETHERTYPE, IP_VERSION_4, 4'd5, 16'd2000, 0, MAX_BYTES + 1, 1'b1);
        send_frame(0);

        // Checksum checking off
        idle_and_configure(1'b0);
        send_ip(IPV4_ETHERTYPE, IP_VERSION_4, 4'd5, 16'd28, 8, 0, 1'b0);
        send_ip(IPV4_ETHERTYPE, IP_VERSION_4, 4'd0, 16'd0, 0, 0, 1'b0);
        send_ip(IPV4_ETHERTYPE, IP_VERSION_4, 4'd2, 16'hFFFF, 2, 0, 1'b0);

        // Sink holds off while tiny frames keep arriving back to back
        idle_and_configure(1'b1);
        hold_off_req = 1'b1;
        repeat (12) begin
            build_raw_frame($urandom_range(1, 3), 1'b0);
            send_frame(0);
        end

        // Random frames, register rewritten every few frames
        random_bytes = 0;
        frame_count  = 0;
        while (random_bytes < RANDOM_BYTES || frame_count < RANDOM_VERDICTS) begin
            if (frame_count % 8 == 7) begin
                idle_and_configure(1'($urandom_range(0, 1)));
                rx_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
            end
            tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
            make_random_frame();
            send_frame(tx_gap_max);
            frame_count++;
        end

        // Drain and report
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (tracker.verdicts_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.fail_count == 0)
            $display("PASS ipv4_rx_header_checker");
        else
            $display("FAIL ipv4_rx_header_checker");
        $finish;
    end

endmodule
